// ===== sv/dwmd_pkg.sv =====
// Shared constants for the distinct-window marker detector.
// Used by dwmd_cell and distinct_window_marker_detector; depends on nothing.
package dwmd_pkg;

  localparam int unsigned SymW            = 8;
  localparam int unsigned WinW            = 4;
  localparam int unsigned MaxWindowDef    = 14;
  localparam int unsigned PositionBitsDef = 20;

  localparam logic [WinW-1:0] WindowReset = WinW'(4);

endpackage

// ===== sv/distinct_window_marker_detector.sv =====
// Top level of the distinct-window marker detector: history chain, run and position tracking.
// Depends on dwmd_pkg and dwmd_cell.
//
// The block takes one symbol per cycle and reports the first position at which the last
// window_size symbols are all different. Each transfer is handled in the cycle it is
// accepted: a chain of MAX_WINDOW-1 cells holds the earlier symbols, compares them all with
// the new one at once and ripples the nearest repeat back to the head of the chain. A result
// appears on the master side the cycle after the symbol that causes it and sits in a single
// output register; a new symbol is taken whenever that register is empty or being emptied,
// so the sustained rate is one symbol per clock. Symbols after a find give no result until
// tlast, which clears the stream state. window_size is taken as 1 when 0 and as MAX_WINDOW
// when larger; the position saturates at 2^POSITION_BITS-1.
module distinct_window_marker_detector #(
  parameter int unsigned MAX_WINDOW    = dwmd_pkg::MaxWindowDef,
  parameter int unsigned POSITION_BITS = dwmd_pkg::PositionBitsDef,
  localparam int unsigned OutDataW     = ((POSITION_BITS + 7) / 8) * 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [dwmd_pkg::WinW-1:0] cfg_wdata_i,     // window_size
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [dwmd_pkg::SymW-1:0] s_axis_tdata,    // [7:0] symbol
  input  logic                      s_axis_tlast,    // end_of_stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [OutDataW-1:0]       m_axis_tdata,    // marker_position, zero padded
  output logic [0:0]                m_axis_tuser     // [0] found
);
  import dwmd_pkg::*;

  localparam int unsigned Hist = MAX_WINDOW - 1;
  localparam int unsigned RunW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned CmpW = (RunW > WinW) ? RunW : WinW;
  localparam logic [POSITION_BITS-1:0] PosMax = '1;

  logic [WinW-1:0]          win_q;
  logic [RunW-1:0]          run_q, run_d;
  logic [POSITION_BITS-1:0] cnt_q, cnt_d, cnt_inc;
  logic                     seen_q, seen_d;
  logic                     out_valid_q, out_valid_d;
  logic                     out_found_q, out_found_d;
  logic [POSITION_BITS-1:0] out_pos_q, out_pos_d;

  logic                     accept, active, marker;
  logic [CmpW-1:0]          win_eff;
  logic [RunW-1:0]          run_tail, run_new;

  logic [SymW-1:0]          chain_sym [Hist];
  logic [RunW-1:0]          chain_run [Hist];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign active        = accept && !seen_q;

  // With no repeat in the run, the run grows by one, bounded by MAX_WINDOW (one more than the history depth).
  assign run_tail = ((run_q >= RunW'(Hist)) ? RunW'(Hist) : run_q) + RunW'(1);

  for (genvar j = 0; j < Hist; j++) begin : g_cell
    dwmd_cell #(
      .Idx  (j),
      .RunW (RunW)
    ) u_cell (
      .clk_i     (clk_i),
      .shift_i   (active),
      .sym_in_i  ((j == 0) ? s_axis_tdata : chain_sym[(j == 0) ? 0 : j - 1]),
      .probe_i   (s_axis_tdata),
      .run_len_i (run_q),
      .run_in_i  ((j == Hist - 1) ? run_tail : chain_run[(j == Hist - 1) ? j : j + 1]),
      .sym_o     (chain_sym[j]),
      .run_out_o (chain_run[j])
    );
  end

  assign run_new = chain_run[0];

  always_comb begin
    if (win_q == '0) begin
      win_eff = CmpW'(1);
    end else if (CmpW'(win_q) > CmpW'(MAX_WINDOW)) begin
      win_eff = CmpW'(MAX_WINDOW);
    end else begin
      win_eff = CmpW'(win_q);
    end
  end

  assign marker  = CmpW'(run_new) >= win_eff;
  assign cnt_inc = (cnt_q == PosMax) ? cnt_q : cnt_q + POSITION_BITS'(1);

  always_comb begin
    run_d       = run_q;
    cnt_d       = cnt_q;
    seen_d      = seen_q;
    out_valid_d = out_valid_q;
    out_found_d = out_found_q;
    out_pos_d   = out_pos_q;

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    if (active) begin
      run_d = run_new;
      cnt_d = cnt_inc;
      if (marker) begin
        seen_d      = 1'b1;
        out_valid_d = 1'b1;
        out_found_d = 1'b1;
        out_pos_d   = cnt_inc;
      end else if (s_axis_tlast) begin
        out_valid_d = 1'b1;
        out_found_d = 1'b0;
        out_pos_d   = '0;
      end
    end

    if (accept && s_axis_tlast) begin
      run_d  = '0;
      cnt_d  = '0;
      seen_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= WindowReset;
      run_q       <= '0;
      cnt_q       <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        win_q <= cfg_wdata_i;
      end
      run_q       <= run_d;
      cnt_q       <= cnt_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_found_q <= out_found_d;
    out_pos_q   <= out_pos_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(out_pos_q);
  assign m_axis_tuser  = out_found_q;

endmodule

// ===== sv/dwmd_cell.sv =====
// One history cell of the detector: holds one earlier symbol and compares it with the new one.
// Depends on dwmd_pkg.
module dwmd_cell #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned RunW = 4
) (
  input  logic                      clk_i,
  input  logic                      shift_i,
  input  logic [dwmd_pkg::SymW-1:0] sym_in_i,   // symbol from the newer neighbor
  input  logic [dwmd_pkg::SymW-1:0] probe_i,    // symbol being taken now
  input  logic [RunW-1:0]           run_len_i,  // current distinct run length
  input  logic [RunW-1:0]           run_in_i,   // run result from the older neighbor
  output logic [dwmd_pkg::SymW-1:0] sym_o,
  output logic [RunW-1:0]           run_out_o
);
  import dwmd_pkg::*;

  logic [SymW-1:0] sym_q;
  logic            hit;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      sym_q <= sym_in_i;
    end
  end

  // Only symbols inside the current run can end it; the nearest hit wins.
  assign hit       = (sym_q == probe_i) && (RunW'(Idx) < run_len_i);
  assign run_out_o = hit ? RunW'(Idx + 1) : run_in_i;
  assign sym_o     = sym_q;

endmodule

// ===== test/distinct_window_marker_detector_test.sv =====
// Self-checking testbench for distinct_window_marker_detector: directed and random symbol streams.
// A scoreboard class predicts each marker report; plain tasks drive the input side and an initial block drives tready.
// Depends on dwmd_pkg and the detector RTL.
module distinct_window_marker_detector_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dwmd_pkg::*;

  localparam int unsigned MaxWin    = MaxWindowDef;
  localparam int unsigned HistDepth = MaxWin - 1;
  localparam int unsigned PosW      = PositionBitsDef;
  localparam int unsigned OutDataW  = ((PosW + 7) / 8) * 8;
  localparam int unsigned RandItems = 1850;
  localparam int unsigned CycleLimit = 300000;
  localparam logic [PosW-1:0] PosMax = '1;

  typedef struct packed {
    logic            found;
    logic [PosW-1:0] position;
  } marker_report_t;

  // Tracks the stream state of the detector and queues the reports it must give.
  class marker_checker;
    logic [WinW-1:0] window;
    logic [SymW-1:0] hist[HistDepth];
    int unsigned     run;
    logic [PosW-1:0] count;
    bit              seen;
    marker_report_t  pending_reports[$];
    int unsigned     errors;

    function new();
      window = WindowReset;
      errors = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      foreach (hist[i]) hist[i] = '0;
      run   = 0;
      count = '0;
      seen  = 1'b0;
    endfunction

    function void set_window(logic [WinW-1:0] value);
      window = value;
    endfunction

    function int unsigned pending();
      return pending_reports.size();
    endfunction

    // Called for every accepted input transfer.
    function void take_symbol(logic [SymW-1:0] sym, logic last);
      int unsigned    eff;
      int unsigned    lim;
      int unsigned    new_run;
      bit             hit;
      marker_report_t rep;
      if (!seen) begin
        eff = (window == 0) ? 1 : ((window > MaxWin) ? MaxWin : window);
        if (count != PosMax) count = count + 1'b1;
        lim     = (run > HistDepth) ? HistDepth : run;
        new_run = lim + 1;
        hit     = 1'b0;
        // The nearest earlier copy of this symbol bounds the new distinct run.
        for (int j = 0; j < lim; j++) begin
          if (!hit && hist[j] == sym) begin
            new_run = j + 1;
            hit     = 1'b1;
          end
        end
        if (new_run > MaxWin) new_run = MaxWin;
        run = new_run;
        for (int j = HistDepth - 1; j > 0; j--) hist[j] = hist[j-1];
        hist[0] = sym;
        if (run >= eff) begin
          seen         = 1'b1;
          rep.found    = 1'b1;
          rep.position = count;
          pending_reports.push_back(rep);
        end else if (last) begin
          rep.found    = 1'b0;
          rep.position = '0;
          pending_reports.push_back(rep);
        end
      end
      if (last) clear_stream();
    endfunction

    // Called for every accepted output transfer.
    function void match_report(logic found, logic [OutDataW-1:0] data);
      marker_report_t exp;
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result found=%0b position=%0d", $time, found, data);
        errors++;
        return;
      end
      exp = pending_reports.pop_front();
      if (found !== exp.found) begin
        $display("%0t: found mismatch expected %0b actual %0b", $time, exp.found, found);
        errors++;
      end
      if (data !== OutDataW'(exp.position)) begin
        $display("%0t: position mismatch expected %0d actual %0d", $time, exp.position, data);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [WinW-1:0]     cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [SymW-1:0]     s_axis_tdata;    // [7:0] symbol
  logic                s_axis_tlast;    // end_of_stream
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;    // marker_position, zero padded
  logic [0:0]          m_axis_tuser;    // [0] found

  distinct_window_marker_detector dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  marker_checker markers = new();

  int unsigned cycles = 0;
  bit          gap_en = 1'b1;
  int unsigned burst_left = 0;
  int unsigned stream_left = 0;
  int unsigned alphabet = 256;
  logic [SymW-1:0] sym_base = '0;
  int unsigned sent = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      markers.match_report(m_axis_tuser[0], m_axis_tdata);
    end
  end

  // Receiver: switches between always ready, random stalls and a periodic pattern.
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned period;
    int unsigned duty;
    int unsigned phase;
    m_axis_tready = 1'b0;
    forever begin
      mode   = $urandom_range(0, 2);
      span   = $urandom_range(20, 200);
      period = $urandom_range(2, 8);
      duty   = $urandom_range(1, period - 1);
      phase  = 0;
      repeat (span) begin
        @(negedge clk_i);
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready <= ((phase % period) < duty);
        endcase
        phase++;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_symbol(input logic [SymW-1:0] sym, input logic last);
    if (gap_en && burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sym;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    markers.take_symbol(sym, last);
    if (burst_left > 0) burst_left--;
    @(negedge clk_i);
  endtask

  // The block must be idle: no transfer offered and every report delivered.
  task automatic write_window(input logic [WinW-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (markers.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    markers.set_window(value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_random_symbol();
    logic [SymW-1:0] sym;
    if (stream_left == 0) begin
      stream_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 24);
      case ($urandom_range(0, 6))
        0: alphabet = 2;
        1: alphabet = 4;
        2: alphabet = 12;
        3: alphabet = 16;
        4: alphabet = 40;
        default: alphabet = 256;
      endcase
      sym_base = SymW'($urandom_range(0, 255));
    end
    sym = sym_base + SymW'($urandom_range(0, alphabet - 1));
    send_symbol(sym, stream_left == 1);
    stream_left--;
    sent++;
  endtask

  initial begin
    int unsigned n;
    logic [WinW-1:0] win;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset window of four: repeat inside the run, then a symbol after the find.
    send_symbol(8'h00, 1'b0);
    send_symbol(8'hFF, 1'b0);
    send_symbol(8'h00, 1'b0);
    send_symbol(8'h01, 1'b0);
    send_symbol(8'h80, 1'b0);
    send_symbol(8'h7F, 1'b1);
    // Stream shorter than the window.
    send_symbol(8'h55, 1'b0);
    send_symbol(8'hAA, 1'b1);
    // Find on the final symbol.
    for (int i = 1; i <= 4; i++) send_symbol(SymW'(i), i == 4);
    // A window of zero behaves as one.
    write_window(4'd0);
    send_symbol(8'h10, 1'b0);
    send_symbol(8'h11, 1'b1);
    // Oversized window, then a smaller one mid-stream that the kept run already meets.
    write_window(4'd15);
    for (int i = 0; i < 6; i++) send_symbol(SymW'(8'h20 + i), 1'b0);
    write_window(4'd3);
    send_symbol(8'h26, 1'b0);
    send_symbol(8'h27, 1'b1);

    while (sent < RandItems) begin
      case ($urandom_range(0, 7))
        0: win = 4'd0;
        1: win = 4'd1;
        2: win = 4'd14;
        3: win = 4'd15;
        default: win = WinW'($urandom_range(0, 15));
      endcase
      write_window(win);
      gap_en = ($urandom_range(0, 3) != 0);
      n = $urandom_range(20, 80);
      repeat (n) send_random_symbol();
    end

    s_axis_tvalid <= 1'b0;
    while (markers.pending() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (markers.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== distinct_window_marker_detector.f =====
sv/dwmd_pkg.sv
sv/dwmd_cell.sv
sv/distinct_window_marker_detector.sv
test/distinct_window_marker_detector_test.sv
